[src/sag_pkg.sv]
// Shared types, constants and tables for the spatial audio gain block.
package sag_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned DIR_W  = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned Q30_W  = 31;

  localparam logic [CFG_W-1:0]  MIN_DIST_RST = 31'd65536;
  localparam logic [CFG_W-1:0]  MAX_DIST_RST = 31'd6553600;
  localparam logic [GAIN_W-1:0] UNITY        = 16'd32768;
  localparam logic [GAIN_W-1:0] LP_FLOOR     = 16'd3277;
  localparam logic [Q30_W-1:0]  Q30_ONE      = 31'd1073741824;
  localparam logic [Q30_W-1:0]  HALF_PI_Q30  = 31'd1686629713;

  localparam int unsigned SQRT_STEPS_DEF = 2;
  localparam int unsigned DIV_STEPS_DEF  = 2;

  // Horner series divisors split into an odd factor and a power-of-two shift
  localparam int unsigned HORNER_N = 5;
  typedef int unsigned horner_tbl_t [HORNER_N];
  localparam horner_tbl_t COS_ODD   = '{45, 7, 15, 3, 1};
  localparam horner_tbl_t COS_SHIFT = '{1, 3, 1, 2, 1};
  localparam horner_tbl_t SIN_ODD   = '{9, 21, 5, 3, 1};
  localparam horner_tbl_t SIN_SHIFT = '{3, 1, 2, 1, 0};

  typedef enum logic [0:0] {
    REG_DIST_LO = 1'b0,
    REG_DIST_HI = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] listener_x;
    logic signed [POS_W-1:0] listener_y;
    logic signed [POS_W-1:0] listener_z;
    logic signed [DIR_W-1:0] right_x;
    logic signed [DIR_W-1:0] right_y;
    logic signed [DIR_W-1:0] right_z;
    logic signed [POS_W-1:0] source_x;
    logic signed [POS_W-1:0] source_y;
    logic signed [POS_W-1:0] source_z;
    logic [GAIN_W-1:0]       occlusion;
  } sag_req_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_left;
    logic [GAIN_W-1:0] gain_right;
    logic [GAIN_W-1:0] distance_gain;
    logic [GAIN_W-1:0] lowpass_coef;
  } sag_rsp_t;

endpackage

[src/sag_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface sag_req_if import sag_pkg::*; ();
  logic     valid;
  logic     ready;
  sag_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sag_rsp_if import sag_pkg::*; ();
  logic     valid;
  logic     ready;
  sag_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/sag_sqrt.sv]
// Pipelined integer square root, a fixed number of root bits per stage.
module sag_sqrt import sag_pkg::*; #(
  parameter int unsigned RAD_W = 64,
  parameter int unsigned STEPS = SQRT_STEPS_DEF,
  parameter int unsigned TAG_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 vld_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [TAG_W-1:0]     tag_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned NST    = (ROOT_W + STEPS - 1) / STEPS;

  logic              vld  [NST+1];
  logic [REM_W-1:0]  rem  [NST+1];
  logic [RAD_W-1:0]  rad  [NST+1];
  logic [ROOT_W-1:0] root [NST+1];
  logic [TAG_W-1:0]  tag  [NST+1];

  assign vld[0]  = vld_i;
  assign rem[0]  = '0;
  assign rad[0]  = rad_i;
  assign root[0] = '0;
  assign tag[0]  = tag_i;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [REM_W-1:0]  rem_c;
    logic [REM_W-1:0]  trial;
    logic [RAD_W-1:0]  rad_c;
    logic [ROOT_W-1:0] root_c;

    always_comb begin
      rem_c  = rem[s];
      rad_c  = rad[s];
      root_c = root[s];
      trial  = '0;
      for (int i = 0; i < STEPS; i++) begin
        if (s * STEPS + i < ROOT_W) begin
          rem_c = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
          rad_c = rad_c << 2;
          trial = REM_W'({root_c, 2'b01});
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[ROOT_W-2:0], 1'b1};
          end else begin
            root_c = {root_c[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= rem_c;
        rad[s+1]  <= rad_c;
        root[s+1] <= root_c;
        tag[s+1]  <= tag[s];
      end
    end
  end

  assign vld_o  = vld[NST];
  assign root_o = root[NST];
  assign tag_o  = tag[NST];

endmodule

[src/sag_div.sv]
// Pipelined restoring divider with a narrow quotient and an overflow flag.
module sag_div import sag_pkg::*; #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DIV_W = 32,
  parameter int unsigned QUO_W = 17,
  parameter int unsigned STEPS = DIV_STEPS_DEF,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned NST = (QUO_W + STEPS - 1) / STEPS;

  logic             vld [NST+1];
  logic [DIV_W-1:0] rem [NST+1];
  logic [QUO_W-1:0] lo  [NST+1];
  logic [QUO_W-1:0] quo [NST+1];
  logic [DIV_W-1:0] den [NST+1];
  logic             ovf [NST+1];
  logic [TAG_W-1:0] tag [NST+1];
  logic [NUM_W-1:0] hi;

  assign hi     = num_i >> QUO_W;
  assign ovf[0] = hi >= NUM_W'(den_i);
  assign rem[0] = ovf[0] ? '0 : DIV_W'(hi);
  assign lo[0]  = num_i[QUO_W-1:0];
  assign quo[0] = '0;
  assign den[0] = den_i;
  assign vld[0] = vld_i;
  assign tag[0] = tag_i;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [DIV_W:0]   part;
    logic [DIV_W-1:0] rem_c;
    logic [QUO_W-1:0] lo_c;
    logic [QUO_W-1:0] quo_c;

    always_comb begin
      rem_c = rem[s];
      lo_c  = lo[s];
      quo_c = quo[s];
      part  = '0;
      for (int i = 0; i < STEPS; i++) begin
        if (s * STEPS + i < QUO_W) begin
          part = {rem_c, lo_c[QUO_W-1]};
          lo_c = lo_c << 1;
          if (part >= {1'b0, den[s]}) begin
            rem_c = DIV_W'(part - {1'b0, den[s]});
            quo_c = (quo_c << 1) | QUO_W'(1);
          end else begin
            rem_c = part[DIV_W-1:0];
            quo_c = quo_c << 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_c;
        lo[s+1]  <= lo_c;
        quo[s+1] <= quo_c;
        den[s+1] <= den[s];
        ovf[s+1] <= ovf[s];
        tag[s+1] <= tag[s];
      end
    end
  end

  assign vld_o = vld[NST];
  assign quo_o = quo[NST];
  assign ovf_o = ovf[NST];
  assign tag_o = tag[NST];

endmodule

[src/sag_trig.sv]
// Pipelined cosine and sine of an angle up to an eighth turn, Horner series in Q30.
module sag_trig import sag_pkg::*; #(
  parameter int unsigned TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_i,
  input  logic [GAIN_W-1:0] ang_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              vld_o,
  output logic [GAIN_W-1:0] cos_o,
  output logic [GAIN_W-1:0] sin_o,
  output logic [TAG_W-1:0]  tag_o
);

  function automatic logic [GAIN_W-1:0] to_q15(input logic [Q30_W-1:0] v);
    logic [31:0] r;
    r = (32'(v) + 32'd16384) >> 15;
    return (r > 32'(UNITY)) ? UNITY : GAIN_W'(r);
  endfunction

  logic             vld_x, vld_x2;
  logic [Q30_W-1:0] x_r, x2_r, xq_r;
  logic [TAG_W-1:0] tag_x, tag_x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_x  <= 1'b0;
      vld_x2 <= 1'b0;
    end else if (en) begin
      vld_x  <= vld_i;
      vld_x2 <= vld_x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= Q30_W'((47'(ang_i) * 47'(HALF_PI_Q30)) >> 16);
      tag_x  <= tag_i;
      x2_r   <= Q30_W'((62'(x_r) * 62'(x_r)) >> 30);
      xq_r   <= x_r;
      tag_x2 <= tag_x;
    end
  end

  logic             va  [HORNER_N+1];
  logic [Q30_W-1:0] tc  [HORNER_N+1];
  logic [Q30_W-1:0] ts  [HORNER_N+1];
  logic [Q30_W-1:0] xa  [HORNER_N+1];
  logic [Q30_W-1:0] x2a [HORNER_N+1];
  logic [TAG_W-1:0] ga  [HORNER_N+1];

  assign va[0]  = vld_x2;
  assign tc[0]  = Q30_ONE;
  assign ts[0]  = Q30_ONE;
  assign xa[0]  = xq_r;
  assign x2a[0] = x2_r;
  assign ga[0]  = tag_x2;

  for (genvar j = 0; j < HORNER_N; j++) begin : g_horner
    localparam int unsigned KC = COS_ODD[j];
    localparam int unsigned KS = SIN_ODD[j];
    localparam int unsigned LC = $clog2(KC);
    localparam int unsigned LS = $clog2(KS);
    localparam logic [63:0] MC = ((64'd1 << (30 + LC)) + 64'(KC) - 64'd1) / 64'(KC);
    localparam logic [63:0] MS = ((64'd1 << (30 + LS)) + 64'(KS) - 64'd1) / 64'(KS);
    localparam bit LAST = (j == HORNER_N - 1);

    logic             vb, vc;
    logic [61:0]      pc_r, ps_r;
    logic [63:0]      mc_r, ms_r;
    logic [Q30_W-1:0] xb, x2b, xc, x2c;
    logic [TAG_W-1:0] gb, gc;
    logic [Q30_W-1:0] mul_s;
    logic [Q30_W-1:0] wc, ws;
    logic [Q30_W-1:0] qc, qs;

    assign mul_s = LAST ? xa[j] : x2a[j];
    assign wc    = Q30_W'(pc_r >> 30) >> COS_SHIFT[j];
    assign ws    = Q30_W'(ps_r >> 30) >> SIN_SHIFT[j];
    assign qc    = Q30_W'(mc_r >> (30 + LC));
    assign qs    = Q30_W'(ms_r >> (30 + LS));

    always_ff @(posedge clk) begin
      if (rst) begin
        vb <= 1'b0;
        vc <= 1'b0;
      end else if (en) begin
        vb <= va[j];
        vc <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pc_r <= 62'(x2a[j]) * 62'(tc[j]);
        ps_r <= 62'(mul_s) * 62'(ts[j]);
        xb   <= xa[j];
        x2b  <= x2a[j];
        gb   <= ga[j];
        mc_r <= 64'(wc) * MC;
        ms_r <= 64'(ws) * MS;
        xc   <= xb;
        x2c  <= x2b;
        gc   <= gb;
      end
    end

    assign va[j+1]  = vc;
    assign tc[j+1]  = Q30_ONE - qc;
    assign ts[j+1]  = LAST ? qs : Q30_ONE - qs;
    assign xa[j+1]  = xc;
    assign x2a[j+1] = x2c;
    assign ga[j+1]  = gc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= va[HORNER_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= to_q15(tc[HORNER_N]);
      sin_o <= to_q15(ts[HORNER_N]);
      tag_o <= ga[HORNER_N];
    end
  end

endmodule

[src/spatial_audio_gain.sv]
// Top level of the spatial audio gain pipeline.
// Each request transaction carries listener and source positions (Q16.16), the
// listener right vector (Q2.14) and an occlusion amount (Q1.15). Each one gives
// exactly one response transaction: left and right equal-power pan gains, the
// inverse-square distance gain and a low-pass coefficient, all Q1.15, in order.
// The near and far distance limits are written through the cfg_we/cfg_index/cfg_wdata
// port; the user must write only while no request is in flight, which goes unchecked.
// Pipeline depth is set by the bit-per-step square root, the two dividers and the
// Horner series of the trig unit.
// One request is taken per cycle while the receiver does not stall; all stages advance together.
// When the receiver stalls, the whole pipeline holds, the response register keeps
// its transaction and req.ready drops until it is taken.
// Reset clears all valid bits and loads the distance registers with their defaults
// of 1.0 and 100.0.
module spatial_audio_gain import sag_pkg::*; #(
  parameter int unsigned SQRT_STEPS = SQRT_STEPS_DEF,
  parameter int unsigned DIV_STEPS  = DIV_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sag_req_if.sink          req,
  sag_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned SQ_TAG_W = 50 + 1 + GAIN_W;
  localparam int unsigned DA_TAG_W = 49 + 4 + GAIN_W + DIST_W;
  localparam int unsigned DP_TAG_W = 31 + 4 + GAIN_W;
  localparam int unsigned TR_TAG_W = GAIN_W + GAIN_W + 1;

  logic [CFG_W-1:0] dist_lo, dist_hi;
  logic             adv;
  logic             out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_lo <= MIN_DIST_RST;
      dist_hi <= MAX_DIST_RST;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_DIST_LO: dist_lo <= cfg_wdata;
        REG_DIST_HI: dist_hi <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = !out_vld || rsp.ready;
  assign req.ready = adv;

  // offsets
  logic signed [POS_W-1:0] lis [3];
  logic signed [POS_W-1:0] src [3];
  logic signed [DIR_W-1:0] rin [3];

  assign lis[0] = req.data.listener_x;
  assign lis[1] = req.data.listener_y;
  assign lis[2] = req.data.listener_z;
  assign src[0] = req.data.source_x;
  assign src[1] = req.data.source_y;
  assign src[2] = req.data.source_z;
  assign rin[0] = req.data.right_x;
  assign rin[1] = req.data.right_y;
  assign rin[2] = req.data.right_z;

  logic                      v0, v1, v2, v3;
  logic signed [POS_W:0]     d0 [3];
  logic signed [DIR_W-1:0]   r0 [3], r1 [3];
  logic [GAIN_W-1:0]         lp0, lp1, lp2, lp3;
  logic [GAIN_W-1:0]         lp_c;

  assign lp_c = (req.data.occlusion > (UNITY - LP_FLOOR)) ? LP_FLOOR
              : UNITY - req.data.occlusion;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= req.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d0[i] <= {src[i][POS_W-1], src[i]} - {lis[i][POS_W-1], lis[i]};
        r0[i] <= rin[i];
      end
      lp0 <= lp_c;
    end
  end

  // range check, halving and magnitude
  logic [2:0]                far_l;
  logic                      far_c, far1, far2, far3;
  logic signed [POS_W:0]     dh_c [3];
  logic signed [POS_W-1:0]   dh1 [3];
  logic [POS_W-2:0]          m1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      far_l[i] = (d0[i][POS_W] != d0[i][POS_W-1])
               || (d0[i][POS_W:POS_W-1] == 2'b11 && d0[i][POS_W-2:0] == '0);
    end
    far_c = |far_l;
    for (int i = 0; i < 3; i++) begin
      dh_c[i] = far_c ? $signed(d0[i] + (POS_W+1)'(d0[i][POS_W])) >>> 1 : d0[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dh1[i] <= dh_c[i][POS_W-1:0];
        m1[i]  <= dh_c[i][POS_W] ? (POS_W-1)'(-dh_c[i]) : (POS_W-1)'(dh_c[i]);
        r1[i]  <= r0[i];
      end
      far1 <= far_c;
      lp1  <= lp0;
    end
  end

  // squares and dot-product terms
  logic [61:0]        sq2 [3];
  logic signed [47:0] pr2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= 62'(m1[i]) * 62'(m1[i]);
        pr2[i] <= 48'(dh1[i]) * 48'(r1[i]);
      end
      far2 <= far1;
      lp2  <= lp1;
    end
  end

  logic [63:0]        sum3;
  logic signed [49:0] dot3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum3 <= 64'(sq2[0]) + 64'(sq2[1]) + 64'(sq2[2]);
      dot3 <= 50'(pr2[0]) + 50'(pr2[1]) + 50'(pr2[2]);
      far3 <= far2;
      lp3  <= lp2;
    end
  end

  // distance
  logic                  vs;
  logic [DIST_W-1:0]     dist_s;
  logic [SQ_TAG_W-1:0]   tag_s;

  sag_sqrt #(
    .RAD_W (64),
    .STEPS (SQRT_STEPS),
    .TAG_W (SQ_TAG_W)
  ) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_i  (v3),
    .rad_i  (sum3),
    .tag_i  ({dot3, far3, lp3}),
    .vld_o  (vs),
    .root_o (dist_s),
    .tag_o  (tag_s)
  );

  logic signed [49:0] dot_s;
  logic               far_s;
  logic [GAIN_W-1:0]  lp_s;
  logic [49:0]        adot_s;

  assign {dot_s, far_s, lp_s} = tag_s;
  assign adot_s = dot_s[49] ? 50'(-dot_s) : 50'(dot_s);

  logic              v4, psign4, pzero4, azero4, aunity4;
  logic [DIST_W-1:0] dist4, dd4;
  logic [48:0]       mag4;
  logic [GAIN_W-1:0] lp4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist4   <= dist_s;
      dd4     <= (dist_s < DIST_W'(dist_lo)) ? DIST_W'(dist_lo) : dist_s;
      aunity4 <= (dist_s == '0) && (dist_lo == '0);
      azero4  <= far_s || (dist_s >= DIST_W'(dist_hi));
      pzero4  <= (dist_s == '0);
      psign4  <= dot_s[49];
      mag4    <= {adot_s[47:0], 1'b0};
      lp4     <= lp_s;
    end
  end

  // attenuation quotient min / max(dist, min) in Q30
  logic                va;
  logic [30:0]         qa;
  logic                ovf_a;
  logic [DA_TAG_W-1:0] tag_a;

  sag_div #(
    .NUM_W (61),
    .DIV_W (DIST_W),
    .QUO_W (31),
    .STEPS (DIV_STEPS),
    .TAG_W (DA_TAG_W)
  ) u_div_atten (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .vld_i (v4),
    .num_i ({dist_lo, 30'd0}),
    .den_i (dd4),
    .tag_i ({mag4, psign4, pzero4, azero4, aunity4, lp4, dist4}),
    .vld_o (va),
    .quo_o (qa),
    .ovf_o (ovf_a),
    .tag_o (tag_a)
  );

  logic [48:0]       mag_a;
  logic              psign_a, pzero_a, azero_a, aunity_a;
  logic [GAIN_W-1:0] lp_a;
  logic [DIST_W-1:0] dist_a;

  assign {mag_a, psign_a, pzero_a, azero_a, aunity_a, lp_a, dist_a} = tag_a;

  // pan magnitude 2*|dot| / dist
  logic                vp;
  logic [16:0]         quo_p;
  logic                ovf_p;
  logic [DP_TAG_W-1:0] tag_p;

  sag_div #(
    .NUM_W (49),
    .DIV_W (DIST_W),
    .QUO_W (17),
    .STEPS (DIV_STEPS),
    .TAG_W (DP_TAG_W)
  ) u_div_pan (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .vld_i (va),
    .num_i (mag_a),
    .den_i (dist_a),
    .tag_i ({qa, psign_a, pzero_a, azero_a, aunity_a || ovf_a && aunity_a, lp_a}),
    .vld_o (vp),
    .quo_o (quo_p),
    .ovf_o (ovf_p),
    .tag_o (tag_p)
  );

  logic [30:0]       qa_p;
  logic              psign_p, pzero_p, azero_p, aunity_p;
  logic [GAIN_W-1:0] lp_p;
  logic [GAIN_W-1:0] pq;

  assign {qa_p, psign_p, pzero_p, azero_p, aunity_p, lp_p} = tag_p;
  assign pq = pzero_p ? '0
            : (ovf_p || quo_p > 17'(UNITY)) ? UNITY : quo_p[GAIN_W-1:0];

  logic              v5, swap5, azero5, aunity5;
  logic [GAIN_W-1:0] ang5, lp5;
  logic [61:0]       sq5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang5    <= UNITY - pq;
      swap5   <= !psign_p && (pq != '0);
      sq5     <= 62'(qa_p) * 62'(qa_p);
      azero5  <= azero_p;
      aunity5 <= aunity_p;
      lp5     <= lp_p;
    end
  end

  logic [16:0]       rnd5;
  logic              v6, swap6;
  logic [GAIN_W-1:0] ang6, lp6, atten6;

  assign rnd5 = 17'((sq5 + 62'(64'd1 << 44)) >> 45);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (azero5) begin
        atten6 <= '0;
      end else if (aunity5 || rnd5 > 17'(UNITY)) begin
        atten6 <= UNITY;
      end else begin
        atten6 <= rnd5[GAIN_W-1:0];
      end
      ang6  <= ang5;
      swap6 <= swap5;
      lp6   <= lp5;
    end
  end

  // pan gains
  logic                vt;
  logic [GAIN_W-1:0]   cos_t, sin_t;
  logic [TR_TAG_W-1:0] tag_t;

  sag_trig #(
    .TAG_W (TR_TAG_W)
  ) u_trig (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .vld_i (v6),
    .ang_i (ang6),
    .tag_i ({atten6, lp6, swap6}),
    .vld_o (vt),
    .cos_o (cos_t),
    .sin_o (sin_t),
    .tag_o (tag_t)
  );

  logic [GAIN_W-1:0] atten_t, lp_t;
  logic              swap_t;
  sag_rsp_t          rsp_q;

  assign {atten_t, lp_t, swap_t} = tag_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vt) begin
      rsp_q.gain_left     <= swap_t ? sin_t : cos_t;
      rsp_q.gain_right    <= swap_t ? cos_t : sin_t;
      rsp_q.distance_gain <= atten_t;
      rsp_q.lowpass_coef  <= lp_t;
    end
  end

  assign rsp.valid = out_vld;
  assign rsp.data  = rsp_q;

endmodule
